@@ rtl/core/fse_pkg.sv @@
package fse_pkg;

    localparam int COL_BITS      = 7;
    localparam int ROW_BITS      = 7;
    localparam int GRID_WIDTH    = 1 << COL_BITS;
    localparam int GRID_HEIGHT   = 1 << ROW_BITS;
    localparam int ADDR_BITS     = COL_BITS + ROW_BITS;
    localparam int CELLS         = 1 << ADDR_BITS;

    localparam int HEAT_BITS     = 8;
    localparam int COLOR_BITS    = 8;
    localparam int PAL_ADDR_BITS = 8;
    localparam int PAL_DEPTH     = 1 << PAL_ADDR_BITS;

    localparam logic [HEAT_BITS-1:0] TOP_INDEX_RESET = 8'd36;

    typedef enum logic [1:0] {
        ACT_SEED    = 2'd0,
        ACT_SPREAD  = 2'd1,
        ACT_READ    = 2'd2,
        ACT_PALETTE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPREAD,
        ST_RD_GRID,
        ST_RD_PAL,
        ST_HOLD
    } t_state;

endpackage

@@ rtl/core/fse_in_if.sv @@
interface fse_in_if;
    import fse_pkg::*;

    logic               valid;
    logic               ready;
    t_action            action;
    logic [1:0]         rand_bits;
    logic signed [15:0] column;
    logic [6:0]         row;
    logic [7:0]         pal_index;
    logic [7:0]         pal_color;

    modport source (
        output valid, action, rand_bits, column, row, pal_index, pal_color,
        input  ready
    );
    modport sink (
        input  valid, action, rand_bits, column, row, pal_index, pal_color,
        output ready
    );
endinterface

@@ rtl/core/fse_out_if.sv @@
interface fse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_color;
    logic       sweep_done;

    modport source (
        output valid, pixel_color, sweep_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, sweep_done,
        output ready
    );
endinterface

@@ rtl/core/fse_cfg_if.sv @@
interface fse_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

@@ rtl/core/fse_ram.sv @@
module fse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/core/fire_spread_effect.sv @@
// Fire effect engine: a grid of heat indices plus a 256-entry color table.
// Requests arrive on i_in and each one produces exactly one result on o_out.
// A seed clears the grid and loads the bottom row with top_index. A spread
// handles the cell under the internal sweep cursor and advances it; the
// result flags the last cell of a sweep. A read returns the color of one cell
// and a palette request writes one color table entry. i_cfg writes top_index
// and is always ready; write it only while the block is idle.
// From acceptance until its result is in the output register, a palette
// write goes straight through, a spread does a grid read and then a write
// back, and a read does a grid read and then a color table read. A seed
// runs a clearing pass over the whole grid, one cell per cycle, and gives
// its result after the last cell. i_in.ready is high only between requests.
// After reset a clearing pass over the whole grid runs with i_in.ready low;
// it writes zeroes only and gives no result. When the receiver
// stalls, the finished result waits in the output register and one more
// request is accepted; that request then holds its result until the output
// register frees up.
module fire_spread_effect (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fse_cfg_if.sink    i_cfg,
    fse_in_if.sink     i_in,
    fse_out_if.source  o_out
);
    import fse_pkg::*;

    t_state                  r_state, n_state;
    logic                    r_fill, n_fill;
    logic [ADDR_BITS-1:0]    r_clr_addr, n_clr_addr;
    logic [COL_BITS-1:0]     r_cur_col, n_cur_col;
    logic [ROW_BITS-1:0]     r_cur_row, n_cur_row;
    logic [HEAT_BITS-1:0]    r_top_index;
    logic [1:0]              r_rand, n_rand;
    logic                    r_out_valid, n_out_valid;
    logic [COLOR_BITS-1:0]   r_out_color, n_out_color;
    logic                    r_out_done, n_out_done;
    logic [COLOR_BITS-1:0]   r_pend_color, n_pend_color;
    logic                    r_pend_done, n_pend_done;

    logic                    in_acc;
    logic                    out_free;
    logic                    fin;
    logic [COLOR_BITS-1:0]   fin_color;
    logic                    fin_done;
    logic                    row_last;
    logic                    col_last;
    logic [ADDR_BITS-1:0]    src_addr;

    logic                    g_we;
    logic [ADDR_BITS-1:0]    g_waddr;
    logic [HEAT_BITS-1:0]    g_wdata;
    logic [ADDR_BITS-1:0]    g_raddr;
    logic [HEAT_BITS-1:0]    g_rdata;

    logic                    p_we;
    logic [PAL_ADDR_BITS-1:0] p_raddr;
    logic [COLOR_BITS-1:0]   p_rdata;

    fse_ram #(.WIDTH(HEAT_BITS), .DEPTH(CELLS)) u_grid (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    fse_ram #(.WIDTH(COLOR_BITS), .DEPTH(PAL_DEPTH)) u_pal (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (i_in.pal_index),
        .i_wdata (i_in.pal_color),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    assign i_cfg.ready       = 1'b1;
    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_color = r_out_color;
    assign o_out.sweep_done  = r_out_done;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign row_last = &r_cur_row;
    assign col_last = &r_cur_col;
    assign src_addr = {r_cur_row, r_cur_col};
    assign p_we     = in_acc && (i_in.action == ACT_PALETTE);
    assign p_raddr  = g_rdata;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_clr_addr   = r_clr_addr;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_rand       = r_rand;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_color  = r_out_color;
        n_out_done   = r_out_done;
        n_pend_color = r_pend_color;
        n_pend_done  = r_pend_done;
        fin          = 1'b0;
        fin_color    = '0;
        fin_done     = 1'b0;
        g_we         = 1'b0;
        g_waddr      = r_clr_addr;
        g_wdata      = '0;
        g_raddr      = src_addr;

        unique case (r_state)
            ST_CLEAR: begin
                g_we = 1'b1;
                // During a seed the bottom row takes the hottest index.
                if (r_fill && (&r_clr_addr[ADDR_BITS-1:COL_BITS])) begin
                    g_wdata = r_top_index;
                end
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                    fin     = r_fill;
                end
            end
            ST_IDLE: begin
                if (i_in.action != ACT_SPREAD) begin
                    g_raddr = {ROW_BITS'(i_in.row), COL_BITS'(i_in.column)};
                end
                n_rand = i_in.rand_bits;
                if (in_acc) begin
                    unique case (i_in.action)
                        ACT_SEED: begin
                            n_state    = ST_CLEAR;
                            n_fill     = 1'b1;
                            n_clr_addr = '0;
                            n_cur_col  = '0;
                            n_cur_row  = ROW_BITS'(1);
                        end
                        ACT_SPREAD:  n_state = ST_SPREAD;
                        ACT_READ:    n_state = ST_RD_GRID;
                        ACT_PALETTE: fin     = 1'b1;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SPREAD: begin
                g_we = 1'b1;
                if (g_rdata == '0) begin
                    g_waddr = {r_cur_row - 1'b1, r_cur_col};
                end else begin
                    // Destination wraps around the whole grid.
                    g_waddr = src_addr - ADDR_BITS'(GRID_WIDTH) + ADDR_BITS'(1)
                              - ADDR_BITS'(r_rand);
                    g_wdata = g_rdata - HEAT_BITS'(r_rand[0]);
                end
                n_state = ST_IDLE;
                fin     = 1'b1;
                if (row_last) begin
                    n_cur_row = ROW_BITS'(1);
                    n_cur_col = r_cur_col + 1'b1;
                    fin_done  = col_last;
                end else begin
                    n_cur_row = r_cur_row + 1'b1;
                end
            end
            ST_RD_GRID: begin
                n_state = ST_RD_PAL;
            end
            ST_RD_PAL: begin
                n_state   = ST_IDLE;
                fin       = 1'b1;
                fin_color = p_rdata;
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_color = r_pend_color;
                    n_out_done  = r_pend_done;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_color = fin_color;
                n_out_done  = fin_done;
            end else begin
                n_state      = ST_HOLD;
                n_pend_color = fin_color;
                n_pend_done  = fin_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_fill      <= 1'b0;
            r_clr_addr  <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= ROW_BITS'(1);
            r_top_index <= TOP_INDEX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_clr_addr  <= n_clr_addr;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_top_index <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rand       <= n_rand;
        r_out_color  <= n_out_color;
        r_out_done   <= n_out_done;
        r_pend_color <= n_pend_color;
        r_pend_done  <= n_pend_done;
    end
endmodule

@@ rtl/core/fse_checker.sv @@
module fse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_action,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_color,
    input logic       i_out_done
);
    import fse_pkg::*;

    // Reset starts the clearing pass: no request taken, no result shown.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("request or result active right after reset");

    // A seed always starts a clearing pass, so the input closes at once.
    a_seed_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_SEED) |=> !i_in_ready)
        else $error("request taken during the clearing pass");

    // Only reads carry a color, only spreads flag the sweep end.
    a_done_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_done && (i_out_color != 8'd0)))
        else $error("result carries both a color and a sweep flag");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");
endmodule

bind fire_spread_effect fse_checker u_fse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_color (o_out.pixel_color),
    .i_out_done  (o_out.sweep_done)
);

@@ dv/tb_fire_spread_effect.sv @@
`timescale 1ns / 100ps

module tb_fire_spread_effect;
    import fse_pkg::*;

    localparam int CLK_PERIOD     = 2;
    localparam int MAX_IDLE       = 12;
    localparam int SETTLE_CYCLES  = 8;
    // The longest quiet stretch is a seed's clearing pass plus one stall on each side.
    localparam int WATCHDOG_LIMIT = 70000;

    typedef struct {
        t_action            action;
        logic [1:0]         rand_bits;
        logic signed [15:0] column;
        logic [6:0]         row;
        logic [7:0]         pal_index;
        logic [7:0]         pal_color;
    } t_fire_request;

    typedef struct {
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  sweep_done;
    } t_fire_result;

    // Tracks the heat grid, the color table and the sweep cursor, and queues the
    // result that each accepted request must produce.
    class t_fire_grid_model;
        logic [HEAT_BITS-1:0]  heat [CELLS];
        logic [COLOR_BITS-1:0] palette [PAL_DEPTH];
        bit                    pal_written [PAL_DEPTH];
        int                    cursor_col;
        int                    cursor_row;
        logic [HEAT_BITS-1:0]  top_index;
        t_fire_result          expected_results [$];
        int                    errors;
        int                    checked;
        int                    sweeps;
        int                    seeds;

        function new();
            foreach (heat[i]) heat[i] = '0;
            foreach (palette[i]) begin
                palette[i]     = '0;
                pal_written[i] = 1'b0;
            end
            cursor_col = 0;
            cursor_row = 1;
            top_index  = TOP_INDEX_RESET;
            errors     = 0;
            checked    = 0;
            sweeps     = 0;
            seeds      = 0;
        endfunction

        function logic [HEAT_BITS-1:0] heat_at(logic signed [15:0] column, logic [6:0] row);
            int c;
            int r;
            c = int'(column) % GRID_WIDTH;
            if (c < 0) begin
                c += GRID_WIDTH;
            end
            r = int'(row) % GRID_HEIGHT;
            return heat[r * GRID_WIDTH + c];
        endfunction

        function void seed_grid();
            foreach (heat[i]) heat[i] = '0;
            for (int i = 0; i < GRID_WIDTH; i++) begin
                heat[(GRID_HEIGHT - 1) * GRID_WIDTH + i] = top_index;
            end
            cursor_col = 0;
            cursor_row = 1;
            seeds++;
        endfunction

        function bit spread_cell(logic [1:0] r);
            int                   src;
            int                   dst;
            logic [HEAT_BITS-1:0] idx;
            bit                   done;
            src  = cursor_row * GRID_WIDTH + cursor_col;
            idx  = heat[src];
            done = 1'b0;
            if (idx == 0) begin
                heat[src - GRID_WIDTH] = '0;
            end else begin
                // The offset may land past either edge; the address wraps over the grid.
                dst = (src + CELLS + 1 - int'(r) - GRID_WIDTH) % CELLS;
                heat[dst] = idx - HEAT_BITS'(r[0]);
            end
            cursor_row++;
            if (cursor_row >= GRID_HEIGHT) begin
                cursor_row = 1;
                cursor_col++;
                if (cursor_col >= GRID_WIDTH) begin
                    cursor_col = 0;
                    done       = 1'b1;
                    sweeps++;
                end
            end
            return done;
        endfunction

        function void note_request(t_fire_request req);
            t_fire_result res;
            res.pixel_color = '0;
            res.sweep_done  = 1'b0;
            case (req.action)
                ACT_SEED: begin
                    seed_grid();
                end
                ACT_SPREAD: begin
                    res.sweep_done = spread_cell(req.rand_bits);
                end
                ACT_READ: begin
                    res.pixel_color = palette[heat_at(req.column, req.row)];
                end
                default: begin
                    palette[req.pal_index]     = req.pal_color;
                    pal_written[req.pal_index] = 1'b1;
                end
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [COLOR_BITS-1:0] color, logic done);
            t_fire_result want;
            if (expected_results.size() == 0) begin
                $error("result with no request pending: pixel_color %0d sweep_done %0d",
                       color, done);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (color !== want.pixel_color) begin
                $error("pixel_color: expected %0d, actual %0d", want.pixel_color, color);
                errors++;
            end
            if (done !== want.sweep_done) begin
                $error("sweep_done: expected %0d, actual %0d", want.sweep_done, done);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    fse_in_if  in_if ();
    fse_out_if out_if ();
    fse_cfg_if cfg_if ();

    t_fire_grid_model grid_model;
    bit               in_quiet;
    bit               out_quiet;
    int               requests_sent;
    int               stuck_cycles;

    fire_spread_effect dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if.sink),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int draw_idle(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic t_fire_request make_request(t_action act, logic [1:0] r,
                                                   logic signed [15:0] col, logic [6:0] row,
                                                   logic [7:0] pidx, logic [7:0] pcol);
        t_fire_request req;
        req.action    = act;
        req.rand_bits = r;
        req.column    = col;
        req.row       = row;
        req.pal_index = pidx;
        req.pal_color = pcol;
        return req;
    endfunction

    // Fields that the action does not use still carry random values.
    function automatic t_fire_request random_request(t_action act);
        return make_request(act, 2'($urandom), 16'($urandom), 7'($urandom),
                            8'($urandom), 8'($urandom));
    endfunction

    task automatic send_request(input t_fire_request req);
        int gap;
        gap = draw_idle(in_quiet);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= req.action;
        in_if.rand_bits <= req.rand_bits;
        in_if.column    <= req.column;
        in_if.row       <= req.row;
        in_if.pal_index <= req.pal_index;
        in_if.pal_color <= req.pal_color;
        do @(posedge clk); while (!in_if.ready);
        grid_model.note_request(req);
        requests_sent++;
    endtask

    // A read must never go through a color entry that was never written, so the
    // entry for the target cell's heat is written first where needed.
    task automatic send_checked_read(input logic signed [15:0] col, input logic [6:0] row);
        t_fire_request        req;
        logic [HEAT_BITS-1:0] h;
        h = grid_model.heat_at(col, row);
        if (!grid_model.pal_written[h]) begin
            req           = random_request(ACT_PALETTE);
            req.pal_index = h;
            send_request(req);
        end
        req        = random_request(ACT_READ);
        req.column = col;
        req.row    = row;
        send_request(req);
    endtask

    task automatic random_traffic(input int count, input int pct_spread, input int pct_read,
                                  input int pct_palette);
        int         pick;
        logic [6:0] row;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) begin
                in_quiet  = ($urandom_range(0, 2) == 0);
                out_quiet = ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < pct_spread) begin
                send_request(random_request(ACT_SPREAD));
            end else if (pick < pct_spread + pct_read) begin
                // Half the reads aim at the bottom rows, where the heat lives.
                row = $urandom_range(0, 1) ? 7'($urandom)
                                           : 7'($urandom_range(GRID_HEIGHT - 4, GRID_HEIGHT - 1));
                send_checked_read(16'($urandom), row);
            end else if (pick < pct_spread + pct_read + pct_palette) begin
                send_request(random_request(ACT_PALETTE));
            end else begin
                send_request(random_request(ACT_SEED));
            end
        end
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (grid_model.expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_top_index(input logic [HEAT_BITS-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        grid_model.top_index = value;
    endtask

    // Result side: stalls a random number of cycles before taking each result.
    initial begin
        int stall;
        out_if.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = draw_idle(out_quiet);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!out_if.valid);
            grid_model.check_result(out_if.pixel_color, out_if.sweep_done);
        end
    end

    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("[fire_spread_effect] ERROR");
            $finish;
        end
    end

    initial begin
        logic [HEAT_BITS-1:0] phase_tops [5];
        grid_model       = new();
        requests_sent    = 0;
        stuck_cycles     = 0;
        in_quiet         = 1'b0;
        out_quiet        = 1'b0;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.action     = ACT_SEED;
        in_if.rand_bits  = '0;
        in_if.column     = '0;
        in_if.row        = '0;
        in_if.pal_index  = '0;
        in_if.pal_color  = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // The block clears its grid after reset before it takes a request.
        do @(posedge clk); while (!in_if.ready);

        send_request(make_request(ACT_PALETTE, 2'd0, 16'sd0, 7'd0, 8'd0, 8'hFF));
        send_request(make_request(ACT_PALETTE, 2'd3, -16'sd1, 7'd127, 8'd255, 8'h00));
        send_request(make_request(ACT_PALETTE, 2'd1, 16'sd3, 7'd5, TOP_INDEX_RESET, 8'h5A));
        send_request(make_request(ACT_PALETTE, 2'd2, 16'sd9, 7'd9, TOP_INDEX_RESET - 8'd1,
                                  8'hC3));
        // Reads of the cleared grid, with columns that wrap from both signs.
        send_checked_read(16'sd0, 7'd0);
        send_checked_read(-16'sd1, 7'd127);
        send_checked_read(16'sh8000, 7'd127);
        send_checked_read(16'sh7FFF, 7'd64);
        send_request(make_request(ACT_SEED, 2'd0, 16'sd0, 7'd0, 8'd0, 8'd0));
        send_checked_read(16'sd5, 7'd127);
        send_checked_read(-16'sd129, 7'd127);
        send_checked_read(16'sd200, 7'd126);
        // Spreads of zero cells near the top, one per value of the random bits.
        for (int r = 0; r < 4; r++) begin
            send_request(make_request(ACT_SPREAD, 2'(r), 16'sd0, 7'd0, 8'd0, 8'd0));
        end
        send_checked_read(16'sd0, 7'd1);
        // A seed in the middle of a sweep sends the cursor back to its start.
        send_request(make_request(ACT_SEED, 2'd3, -16'sd1, 7'd127, 8'd255, 8'd255));
        send_request(make_request(ACT_SPREAD, 2'd1, 16'sd0, 7'd0, 8'd0, 8'd0));

        phase_tops[0] = 8'd255;
        phase_tops[1] = 8'd0;
        phase_tops[2] = 8'd1;
        phase_tops[3] = 8'($urandom_range(2, 253));
        phase_tops[4] = 8'd128;
        foreach (phase_tops[p]) begin
            settle();
            write_top_index(phase_tops[p]);
            send_request(random_request(ACT_SEED));
            if (p == 0) begin
                // A longer run without seeds carries the heat up past the bottom row.
                random_traffic(200, 94, 5, 1);
            end else begin
                random_traffic(90, 85, 9, 4);
            end
        end

        settle();
        $display("Ran %0d requests, %0d seeds and %0d full sweeps; %0d results checked.",
                 requests_sent, grid_model.seeds, grid_model.sweeps, grid_model.checked);
        $display("Seed heat values used: %0d at reset, then %0d, %0d, %0d, %0d, %0d.",
                 TOP_INDEX_RESET, phase_tops[0], phase_tops[1], phase_tops[2], phase_tops[3],
                 phase_tops[4]);
        if (grid_model.errors == 0 && grid_model.expected_results.size() == 0) begin
            $display("[fire_spread_effect] OK");
        end else begin
            $display("[fire_spread_effect] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/fse_pkg.sv
rtl/core/fse_in_if.sv
rtl/core/fse_out_if.sv
rtl/core/fse_cfg_if.sv
rtl/core/fse_ram.sv
rtl/core/fire_spread_effect.sv
rtl/core/fse_checker.sv
dv/tb_fire_spread_effect.sv
